[src/i2c_rrm_pkg.sv]
// Package for the I2C register-read master.
// Holds the request and result payload types and the sequence phase codes.
// Used by every module of the block; depends on nothing.
package i2c_rrm_pkg;

  localparam int unsigned BitsPerByte = 8;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START1    = 5'd1,
    PH_ADDR_W    = 5'd2,
    PH_ACK_AW    = 5'd3,
    PH_REG       = 5'd4,
    PH_ACK_REG   = 5'd5,
    PH_STOP_MID  = 5'd6,
    PH_START2    = 5'd7,
    PH_ADDR_R    = 5'd8,
    PH_ACK_AR    = 5'd9,
    PH_RX        = 5'd10,
    PH_MACK      = 5'd11,
    PH_STOP_FIN  = 5'd12,
    PH_STOP_END  = 5'd13
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_NAK = 2'd1,
    ST_REG_NAK  = 2'd2,
    ST_RADR_NAK = 2'd3
  } status_e;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] device_address;
    logic [7:0] register_number;
    logic [7:0] byte_count;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } res_t;

endpackage

[src/i2c_register_read_master.sv]
// I2C register-read master: every request (command or tick) yields one result.
// A request's result is registered: in the result register, or in the skid stage on a stall.
// Throughput: one request per cycle; a result stall closes the input only once the
// skid stage holds a result. Reset: asynchronous, active low; the sequencer returns
// to idle, pins released, and no result is pending.
module i2c_register_read_master #(
  parameter int unsigned MAX_READ_LENGTH = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2c_rrm_pkg::req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2c_rrm_pkg::res_t  out_data_o
);

  i2c_rrm_pkg::res_t step_res;
  logic              step;

  assign step = in_valid_i && !in_stall_o;

  i2c_rrm_core #(
    .MAX_READ_LENGTH(MAX_READ_LENGTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_data_i),
    .res_o  (step_res)
  );

  i2c_rrm_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (step_res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[src/i2c_rrm_core.sv]
// Sequencer of the I2C register-read master: state registers and the
// combinational step that turns one request into one result.
// Depends on i2c_rrm_pkg.
module i2c_rrm_core #(
  parameter int unsigned MAX_READ_LENGTH = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  i2c_rrm_pkg::req_t  req_i,
  output i2c_rrm_pkg::res_t  res_o
);

  localparam logic [7:0] MaxLen  = 8'(MAX_READ_LENGTH);
  localparam logic [2:0] LastBit = 3'(i2c_rrm_pkg::BitsPerByte - 1);

  i2c_rrm_pkg::phase_e phase_q, phase_d;
  logic       half_q, half_d;
  logic [2:0] bitpos_q, bitpos_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] reg_q, reg_d;
  logic [1:0] err_q, err_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       valid;
  logic [7:0] rx_byte;
  logic       done;
  logic [1:0] stat;
  logic [7:0] cnt;
  logic [7:0] rx_shift;
  logic [7:0] remain_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2c_rrm_pkg::PH_IDLE;
      half_q   <= 1'b0;
      bitpos_q <= '0;
      shift_q  <= '0;
      remain_q <= '0;
      addr_q   <= '0;
      reg_q    <= '0;
      err_q    <= '0;
      scl_q    <= 1'b0;
      sda_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      half_q   <= half_d;
      bitpos_q <= bitpos_d;
      shift_q  <= shift_d;
      remain_q <= remain_d;
      addr_q   <= addr_d;
      reg_q    <= reg_d;
      err_q    <= err_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    half_d   = half_q;
    bitpos_d = bitpos_q;
    shift_d  = shift_q;
    remain_d = remain_q;
    addr_d   = addr_q;
    reg_d    = reg_q;
    err_d    = err_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    valid    = 1'b0;
    rx_byte  = '0;
    done     = 1'b0;
    stat     = i2c_rrm_pkg::ST_OK;
    cnt      = req_i.byte_count;
    if (cnt == 8'd0) cnt = 8'd1;
    if (cnt > MaxLen) cnt = MaxLen;
    rx_shift   = {shift_q[6:0], req_i.sda_sample};
    remain_dec = (remain_q != 8'd0) ? remain_q - 8'd1 : 8'd0;

    if (req_i.kind == i2c_rrm_pkg::KIND_CMD) begin
      if (phase_q == i2c_rrm_pkg::PH_IDLE) begin
        addr_d   = req_i.device_address;
        reg_d    = req_i.register_number;
        remain_d = cnt;
        err_d    = i2c_rrm_pkg::ST_OK;
        half_d   = 1'b0;
        bitpos_d = '0;
        shift_d  = '0;
        scl_d    = 1'b0;
        sda_d    = 1'b0;
        phase_d  = i2c_rrm_pkg::PH_START1;
      end
    end else begin
      case (phase_q)
        i2c_rrm_pkg::PH_IDLE: begin
          scl_d = 1'b0;
          sda_d = 1'b0;
        end
        i2c_rrm_pkg::PH_START1, i2c_rrm_pkg::PH_START2: begin
          scl_d = 1'b0;
          if (!half_q) begin
            sda_d  = 1'b0;
            half_d = 1'b1;
          end else begin
            sda_d    = 1'b1;
            half_d   = 1'b0;
            bitpos_d = '0;
            if (phase_q == i2c_rrm_pkg::PH_START1) begin
              shift_d = addr_q;
              phase_d = i2c_rrm_pkg::PH_ADDR_W;
            end else begin
              shift_d = addr_q + 8'd1;
              phase_d = i2c_rrm_pkg::PH_ADDR_R;
            end
          end
        end
        i2c_rrm_pkg::PH_ADDR_W, i2c_rrm_pkg::PH_REG, i2c_rrm_pkg::PH_ADDR_R: begin
          scl_d = !half_q;
          sda_d = !shift_q[7];
          if (!half_q) begin
            half_d = 1'b1;
          end else begin
            half_d  = 1'b0;
            shift_d = {shift_q[6:0], 1'b0};
            if (bitpos_q == LastBit) begin
              bitpos_d = '0;
              case (phase_q)
                i2c_rrm_pkg::PH_ADDR_W: phase_d = i2c_rrm_pkg::PH_ACK_AW;
                i2c_rrm_pkg::PH_REG:    phase_d = i2c_rrm_pkg::PH_ACK_REG;
                default:                phase_d = i2c_rrm_pkg::PH_ACK_AR;
              endcase
            end else begin
              bitpos_d = bitpos_q + 3'd1;
            end
          end
        end
        i2c_rrm_pkg::PH_ACK_AW, i2c_rrm_pkg::PH_ACK_REG, i2c_rrm_pkg::PH_ACK_AR: begin
          sda_d = 1'b0;
          if (!half_q) begin
            scl_d  = 1'b1;
            half_d = 1'b1;
          end else begin
            scl_d    = 1'b0;
            half_d   = 1'b0;
            bitpos_d = '0;
            if (req_i.sda_sample) begin
              phase_d = i2c_rrm_pkg::PH_STOP_FIN;
              case (phase_q)
                i2c_rrm_pkg::PH_ACK_AW:  err_d = i2c_rrm_pkg::ST_ADDR_NAK;
                i2c_rrm_pkg::PH_ACK_REG: err_d = i2c_rrm_pkg::ST_REG_NAK;
                default:                 err_d = i2c_rrm_pkg::ST_RADR_NAK;
              endcase
            end else begin
              case (phase_q)
                i2c_rrm_pkg::PH_ACK_AW: begin
                  shift_d = reg_q;
                  phase_d = i2c_rrm_pkg::PH_REG;
                end
                i2c_rrm_pkg::PH_ACK_REG: begin
                  shift_d = '0;
                  phase_d = i2c_rrm_pkg::PH_STOP_MID;
                end
                default: begin
                  shift_d = '0;
                  phase_d = i2c_rrm_pkg::PH_RX;
                end
              endcase
            end
          end
        end
        i2c_rrm_pkg::PH_STOP_MID, i2c_rrm_pkg::PH_STOP_FIN: begin
          sda_d = 1'b1;
          if (!half_q) begin
            scl_d  = 1'b1;
            half_d = 1'b1;
          end else begin
            scl_d   = 1'b0;
            half_d  = 1'b0;
            phase_d = (phase_q == i2c_rrm_pkg::PH_STOP_MID) ? i2c_rrm_pkg::PH_START2
                                                            : i2c_rrm_pkg::PH_STOP_END;
          end
        end
        i2c_rrm_pkg::PH_RX: begin
          sda_d = 1'b0;
          if (!half_q) begin
            scl_d  = 1'b1;
            half_d = 1'b1;
          end else begin
            scl_d   = 1'b0;
            half_d  = 1'b0;
            shift_d = rx_shift;
            if (bitpos_q == LastBit) begin
              bitpos_d = '0;
              valid    = 1'b1;
              rx_byte  = rx_shift;
              phase_d  = i2c_rrm_pkg::PH_MACK;
            end else begin
              bitpos_d = bitpos_q + 3'd1;
            end
          end
        end
        i2c_rrm_pkg::PH_MACK: begin
          sda_d = (remain_q > 8'd1);
          if (!half_q) begin
            scl_d  = 1'b1;
            half_d = 1'b1;
          end else begin
            scl_d    = 1'b0;
            half_d   = 1'b0;
            remain_d = remain_dec;
            shift_d  = '0;
            phase_d  = (remain_dec != 8'd0) ? i2c_rrm_pkg::PH_RX : i2c_rrm_pkg::PH_STOP_FIN;
          end
        end
        i2c_rrm_pkg::PH_STOP_END: begin
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          half_d  = 1'b0;
          done    = 1'b1;
          stat    = err_q;
          phase_d = i2c_rrm_pkg::PH_IDLE;
        end
        default: begin
          scl_d    = 1'b0;
          sda_d    = 1'b0;
          half_d   = 1'b0;
          bitpos_d = '0;
          phase_d  = i2c_rrm_pkg::PH_IDLE;
        end
      endcase
    end

    res_o.scl_pull_low = scl_d;
    res_o.sda_pull_low = sda_d;
    res_o.byte_valid   = valid;
    res_o.read_byte    = rx_byte;
    res_o.done_res     = done;
    res_o.status       = stat;
    res_o.busy_res     = (phase_d != i2c_rrm_pkg::PH_IDLE);
  end

endmodule

[src/i2c_rrm_skid.sv]
// Result register with a skid stage for the I2C register-read master.
// Lets a new request enter while a finished result waits on a stall.
// Depends on i2c_rrm_pkg.
module i2c_rrm_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  i2c_rrm_pkg::res_t  push_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2c_rrm_pkg::res_t  out_data_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  i2c_rrm_pkg::res_t main_q, main_d;
  i2c_rrm_pkg::res_t skid_q, skid_d;
  logic              push;
  logic              free;

  assign push_stall_o = skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign free         = !main_valid_q || !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (free) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("Skid stage holds a result while the result register is empty.");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (main_valid_q && !skid_valid_q))
    else $error("Skid stage did not move into the result register.");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && main_valid_q && out_stall_i) |=> (skid_valid_q && main_valid_q))
    else $error("A request arriving under stall was not caught by the skid stage.");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && out_stall_i) |=> (main_valid_q && main_q == $past(main_q)))
    else $error("A stalled result changed.");

endmodule

[sim/i2c_register_read_master_test.sv]
// Self-checking testbench for the I2C register-read master.
// Drives commands and SDA-sampling ticks, predicts every result in a scoreboard class
// and compares field by field. Depends on i2c_rrm_pkg and i2c_register_read_master.
module i2c_register_read_master_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReadLen = 255;
  localparam int CycleLimit = 400000;
  localparam int ReportCap = 40;

  class i2c_read_scoreboard;
    i2c_rrm_pkg::phase_e  phase;
    logic                 half;
    logic [2:0]           bit_pos;
    logic [7:0]           shreg;
    logic [7:0]           remaining;
    logic [7:0]           dev_addr;
    logic [7:0]           reg_num;
    i2c_rrm_pkg::status_e err;
    logic                 scl;
    logic                 sda;
    i2c_rrm_pkg::res_t    bus_results_q[$];
    int                   errors;
    int                   checked;
    int                   reads_started;
    int                   bytes_rx;
    int                   done_by_status[4];

    function new();
      phase = i2c_rrm_pkg::PH_IDLE;
      half = 1'b0;
      bit_pos = '0;
      shreg = '0;
      remaining = '0;
      dev_addr = '0;
      reg_num = '0;
      err = i2c_rrm_pkg::ST_OK;
      scl = 1'b0;
      sda = 1'b0;
      errors = 0;
      checked = 0;
      reads_started = 0;
      bytes_rx = 0;
      foreach (done_by_status[i]) done_by_status[i] = 0;
    endfunction

    function void shift_out(i2c_rrm_pkg::phase_e ack_ph);
      scl = ~half;
      sda = ~shreg[7];
      if (!half) begin
        half = 1'b1;
        return;
      end
      half = 1'b0;
      shreg = shreg << 1;
      if (bit_pos == 3'd7) begin
        bit_pos = '0;
        phase = ack_ph;
      end else begin
        bit_pos++;
      end
    endfunction

    function void ack_slot(logic sda_in, i2c_rrm_pkg::phase_e next_ph, logic [7:0] load,
                           i2c_rrm_pkg::status_e code);
      sda = 1'b0;
      if (!half) begin
        scl = 1'b1;
        half = 1'b1;
        return;
      end
      scl = 1'b0;
      half = 1'b0;
      bit_pos = '0;
      if (sda_in) begin
        err = code;
        phase = i2c_rrm_pkg::PH_STOP_FIN;
      end else begin
        shreg = load;
        phase = next_ph;
      end
    endfunction

    function void stop_half(i2c_rrm_pkg::phase_e next_ph);
      sda = 1'b1;
      if (!half) begin
        scl = 1'b1;
        half = 1'b1;
        return;
      end
      scl = 1'b0;
      half = 1'b0;
      phase = next_ph;
    endfunction

    function void start_half(i2c_rrm_pkg::phase_e next_ph, logic [7:0] load);
      scl = 1'b0;
      if (!half) begin
        sda = 1'b0;
        half = 1'b1;
        return;
      end
      sda = 1'b1;
      half = 1'b0;
      bit_pos = '0;
      shreg = load;
      phase = next_ph;
    endfunction

    function void note_request(i2c_rrm_pkg::req_t r);
      i2c_rrm_pkg::res_t e;
      int unsigned       cnt;
      e = '0;
      if (r.kind == i2c_rrm_pkg::KIND_CMD) begin
        if (phase == i2c_rrm_pkg::PH_IDLE) begin
          cnt = r.byte_count;
          if (cnt == 0) cnt = 1;
          if (cnt > MaxReadLen) cnt = MaxReadLen;
          dev_addr = r.device_address;
          reg_num = r.register_number;
          remaining = cnt[7:0];
          err = i2c_rrm_pkg::ST_OK;
          half = 1'b0;
          bit_pos = '0;
          shreg = '0;
          scl = 1'b0;
          sda = 1'b0;
          phase = i2c_rrm_pkg::PH_START1;
          reads_started++;
        end
      end else begin
        case (phase)
          i2c_rrm_pkg::PH_IDLE: begin
            scl = 1'b0;
            sda = 1'b0;
          end
          i2c_rrm_pkg::PH_START1: start_half(i2c_rrm_pkg::PH_ADDR_W, dev_addr);
          i2c_rrm_pkg::PH_ADDR_W: shift_out(i2c_rrm_pkg::PH_ACK_AW);
          i2c_rrm_pkg::PH_ACK_AW:
            ack_slot(r.sda_sample, i2c_rrm_pkg::PH_REG, reg_num, i2c_rrm_pkg::ST_ADDR_NAK);
          i2c_rrm_pkg::PH_REG: shift_out(i2c_rrm_pkg::PH_ACK_REG);
          i2c_rrm_pkg::PH_ACK_REG:
            ack_slot(r.sda_sample, i2c_rrm_pkg::PH_STOP_MID, 8'h00, i2c_rrm_pkg::ST_REG_NAK);
          i2c_rrm_pkg::PH_STOP_MID: stop_half(i2c_rrm_pkg::PH_START2);
          i2c_rrm_pkg::PH_START2: start_half(i2c_rrm_pkg::PH_ADDR_R, dev_addr + 8'd1);
          i2c_rrm_pkg::PH_ADDR_R: shift_out(i2c_rrm_pkg::PH_ACK_AR);
          i2c_rrm_pkg::PH_ACK_AR:
            ack_slot(r.sda_sample, i2c_rrm_pkg::PH_RX, 8'h00, i2c_rrm_pkg::ST_RADR_NAK);
          i2c_rrm_pkg::PH_RX: begin
            sda = 1'b0;
            if (!half) begin
              scl = 1'b1;
              half = 1'b1;
            end else begin
              scl = 1'b0;
              half = 1'b0;
              shreg = {shreg[6:0], r.sda_sample};
              if (bit_pos == 3'd7) begin
                bit_pos = '0;
                e.byte_valid = 1'b1;
                e.read_byte = shreg;
                bytes_rx++;
                phase = i2c_rrm_pkg::PH_MACK;
              end else begin
                bit_pos++;
              end
            end
          end
          i2c_rrm_pkg::PH_MACK: begin
            sda = (remaining > 8'd1);
            if (!half) begin
              scl = 1'b1;
              half = 1'b1;
            end else begin
              scl = 1'b0;
              half = 1'b0;
              if (remaining != 0) remaining--;
              shreg = '0;
              phase = (remaining != 0) ? i2c_rrm_pkg::PH_RX : i2c_rrm_pkg::PH_STOP_FIN;
            end
          end
          i2c_rrm_pkg::PH_STOP_FIN: stop_half(i2c_rrm_pkg::PH_STOP_END);
          i2c_rrm_pkg::PH_STOP_END: begin
            scl = 1'b0;
            sda = 1'b0;
            half = 1'b0;
            e.done_res = 1'b1;
            e.status = err;
            done_by_status[err]++;
            phase = i2c_rrm_pkg::PH_IDLE;
          end
          default: begin
            scl = 1'b0;
            sda = 1'b0;
            half = 1'b0;
            bit_pos = '0;
            phase = i2c_rrm_pkg::PH_IDLE;
          end
        endcase
      end
      e.scl_pull_low = scl;
      e.sda_pull_low = sda;
      e.busy_res = (phase != i2c_rrm_pkg::PH_IDLE);
      bus_results_q.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= ReportCap) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
    endtask

    task check_result(i2c_rrm_pkg::res_t got);
      i2c_rrm_pkg::res_t want;
      if (bus_results_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", checked));
      end else begin
        want = bus_results_q.pop_front();
        compare_field("scl_pull_low", 8'(got.scl_pull_low), 8'(want.scl_pull_low));
        compare_field("sda_pull_low", 8'(got.sda_pull_low), 8'(want.sda_pull_low));
        compare_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
        compare_field("read_byte", got.read_byte, want.read_byte);
        compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
        compare_field("status", 8'(got.status), 8'(want.status));
        compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      end
      checked++;
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  i2c_rrm_pkg::req_t in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  i2c_rrm_pkg::res_t out_data_o;

  i2c_read_scoreboard sb = new();
  int sender_idle_pct = 35;
  int receiver_idle_pct = 54;
  int sent = 0;
  int reads_issued = 0;
  int cycle_count = 0;

  i2c_register_read_master #(
    .MAX_READ_LENGTH(MaxReadLen)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(input i2c_rrm_pkg::req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick(input logic sda_level);
    i2c_rrm_pkg::req_t r;
    r.kind = i2c_rrm_pkg::KIND_TICK;
    r.device_address = 8'($urandom);
    r.register_number = 8'($urandom);
    r.byte_count = 8'($urandom);
    r.sda_sample = sda_level;
    send_request(r);
  endtask

  task automatic send_command(input logic [7:0] addr, input logic [7:0] reg_n,
                              input logic [7:0] cnt);
    i2c_rrm_pkg::req_t r;
    r.kind = i2c_rrm_pkg::KIND_CMD;
    r.device_address = addr;
    r.register_number = reg_n;
    r.byte_count = cnt;
    r.sda_sample = 1'($urandom_range(1));
    send_request(r);
  endtask

  // The slave acknowledges unless this transfer is set to refuse at the given slot.
  function automatic logic slave_sda(input int nack_at);
    if (sb.half) begin
      case (sb.phase)
        i2c_rrm_pkg::PH_ACK_AW:  return nack_at == 1;
        i2c_rrm_pkg::PH_ACK_REG: return nack_at == 2;
        i2c_rrm_pkg::PH_ACK_AR:  return nack_at == 3;
        default: ;
      endcase
    end
    return 1'($urandom_range(1));
  endfunction

  task automatic run_read(input logic [7:0] addr, input logic [7:0] reg_n,
                          input logic [7:0] cnt, input int nack_at);
    send_command(addr, reg_n, cnt);
    reads_issued++;
    while (sb.phase != i2c_rrm_pkg::PH_IDLE) begin
      if ($urandom_range(99) < 3) send_command(8'($urandom), 8'($urandom), 8'($urandom));
      else send_tick(slave_sda(nack_at));
    end
  endtask

  task automatic run_phase(input int target);
    int start_count;
    int nack_at;
    int pick;
    logic [7:0] cnt;
    start_count = sent;
    while (sent - start_count < target) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(1)));
      if (reads_issued < 4) begin
        nack_at = reads_issued;
      end else begin
        pick = $urandom_range(11);
        nack_at = (pick < 3) ? pick + 1 : 0;
      end
      pick = $urandom_range(15);
      if (pick == 0) cnt = 8'd0;
      else if (pick == 1) cnt = 8'($urandom_range(5, 12));
      else cnt = 8'($urandom_range(1, 4));
      run_read(8'($urandom), 8'($urandom), cnt, nack_at);
    end
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.bus_results_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_tick(1'b0);
    send_tick(1'b1);
    send_command(8'hFF, 8'h00, 8'h00);
    send_command(8'h00, 8'hFF, 8'hFF);
    while (sb.phase != i2c_rrm_pkg::PH_IDLE) send_tick(slave_sda(1));
    reads_issued = 1;
    drain_results();

    run_phase(450);
    drain_results();

    sender_idle_pct = 54;
    receiver_idle_pct = 35;
    run_read(8'hFF, 8'hFF, 8'd1, 0);
    run_phase(450);
    drain_results();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    run_read(8'($urandom), 8'($urandom), 8'd10, 0);
    run_phase(450);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.bus_results_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.bus_results_q.size()));

    $display("Covered %0d requests, %0d register reads started, %0d bytes received.",
             sent, sb.reads_started, sb.bytes_rx);
    $display("Finished reads: %0d clean, NACK aborts %0d address, %0d register, %0d read.",
             sb.done_by_status[i2c_rrm_pkg::ST_OK], sb.done_by_status[i2c_rrm_pkg::ST_ADDR_NAK],
             sb.done_by_status[i2c_rrm_pkg::ST_REG_NAK],
             sb.done_by_status[i2c_rrm_pkg::ST_RADR_NAK]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/i2c_rrm_pkg.sv
src/i2c_rrm_core.sv
src/i2c_rrm_skid.sv
src/i2c_register_read_master.sv
sim/i2c_register_read_master_test.sv
